// ===== design/ccb_pkg.sv =====
// Shared types and constants for the coverage counter bank.
package ccb_pkg;

    localparam int DATA_W       = 32;
    localparam int EVENT_W      = 16;
    localparam int LINE_COUNT_W = 11;
    localparam int INDEX_W      = 10;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RESET = 11'd1024;

    // Word index of the line count register on the configuration port.
    localparam logic CFG_IDX_LINE_COUNT = 1'b0;

    localparam logic [1:0] OP_TENT = 2'd0;
    localparam logic [1:0] OP_PASS = 2'd1;
    localparam logic [1:0] OP_FAIL = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_RD      = 6'b000100,
        ST_WR      = 6'b001000,
        ST_FOLD_RD = 6'b010000,
        ST_FOLD_WR = 6'b100000
    } ccb_state_t;

    // Write enables of the three counter banks.
    typedef struct packed {
        logic pos;
        logic neg;
        logic temp;
    } bank_we_t;

endpackage

// ===== design/coverage_counter_bank.sv =====
// Top level of the coverage counter bank: configuration port, sequencer and three banks.
// A hit or read beat taken with start while busy is low passes the read and write states
// and shows on done in the cycle busy drops, so a new beat waits until the last is through.
// A pass or fail hit with a tentative hit pending first walks the lines in use, reading and
// writing each in turn; a beat with a bad index shows on done in the next cycle with busy low.
// Reset sweeps every line of all three banks to zero with busy high; done cannot stall.
module coverage_counter_bank #(
    parameter int MAX_LINES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ccb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ccb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ccb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,

    // Command beat.
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [ccb_pkg::INDEX_W-1:0]        line_index,

    // Result beat, valid for the single cycle that done is high.
    output logic                               done,
    output logic [ccb_pkg::DATA_W-1:0]         pos_count,
    output logic [ccb_pkg::DATA_W-1:0]         neg_count,
    output logic [ccb_pkg::DATA_W-1:0]         temp_count,
    output logic                               dump_due,
    output logic                               bad_index
);
    import ccb_pkg::*;

    localparam int AW = $clog2(MAX_LINES);

    logic [LINE_COUNT_W-1:0] line_count_reg, line_count_next;
    logic                    cfg_write;
    logic                    cfg_sel_line_count;

    bank_we_t                bank_we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic [DATA_W-1:0]       wdata;
    logic [DATA_W-1:0]       pos_rd;
    logic [DATA_W-1:0]       neg_rd;
    logic [DATA_W-1:0]       temp_rd;

    // The port never waits. Register words are selected by address bit 2; writes to
    // the unused word are dropped.
    assign pready             = 1'b1;
    assign cfg_write          = psel && penable && pwrite && pready;
    assign cfg_sel_line_count = (paddr[2] == CFG_IDX_LINE_COUNT);

    always_comb
    begin
        line_count_next = line_count_reg;
        if (cfg_write && cfg_sel_line_count)
        begin
            line_count_next = pwdata[LINE_COUNT_W-1:0];
        end
    end

    always_comb
    begin
        if (cfg_sel_line_count)
        begin
            prdata = APB_DATA_W'(line_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_COUNT_RESET;
        end
        else
        begin
            line_count_reg <= line_count_next;
        end
    end

    // The sequencer owns the only adder and steps the banks through reads and writes.
    ccb_ctrl #(
        .MAX_LINES (MAX_LINES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_count (line_count_reg),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .line_index (line_index),
        .bank_we    (bank_we),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .pos_rd     (pos_rd),
        .neg_rd     (neg_rd),
        .temp_rd    (temp_rd),
        .done       (done),
        .pos_count  (pos_count),
        .neg_count  (neg_count),
        .temp_count (temp_count),
        .dump_due   (dump_due),
        .bad_index  (bad_index)
    );

    // All three banks share one address pair; only the write enables differ.
    ccb_bank_mem #(
        .DEPTH (MAX_LINES)
    ) u_pos_bank (
        .clk   (clk),
        .we    (bank_we.pos),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (pos_rd)
    );

    ccb_bank_mem #(
        .DEPTH (MAX_LINES)
    ) u_neg_bank (
        .clk   (clk),
        .we    (bank_we.neg),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (neg_rd)
    );

    ccb_bank_mem #(
        .DEPTH (MAX_LINES)
    ) u_temp_bank (
        .clk   (clk),
        .we    (bank_we.temp),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (temp_rd)
    );

endmodule

// ===== design/ccb_bank_mem.sv =====
// One bank of 32-bit counters: single write port, single registered read port.
module ccb_bank_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ccb_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [ccb_pkg::DATA_W-1:0] rdata
);
    import ccb_pkg::*;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ccb_ctrl.sv =====
// Sequencer and shared 32-bit adder that drive the three counter banks.
module ccb_ctrl #(
    parameter int MAX_LINES = 1024,
    localparam int AW = $clog2(MAX_LINES)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ccb_pkg::LINE_COUNT_W-1:0] line_count,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       opcode,
    input  logic [ccb_pkg::INDEX_W-1:0]      line_index,
    output ccb_pkg::bank_we_t                bank_we,
    output logic [AW-1:0]                    waddr,
    output logic [ccb_pkg::DATA_W-1:0]       wdata,
    output logic [AW-1:0]                    raddr,
    input  logic [ccb_pkg::DATA_W-1:0]       pos_rd,
    input  logic [ccb_pkg::DATA_W-1:0]       neg_rd,
    input  logic [ccb_pkg::DATA_W-1:0]       temp_rd,
    output logic                             done,
    output logic [ccb_pkg::DATA_W-1:0]       pos_count,
    output logic [ccb_pkg::DATA_W-1:0]       neg_count,
    output logic [ccb_pkg::DATA_W-1:0]       temp_count,
    output logic                             dump_due,
    output logic                             bad_index
);
    import ccb_pkg::*;

    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int LW = (CW > LINE_COUNT_W) ? CW : LINE_COUNT_W;

    ccb_state_t         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      fold_addr_reg, fold_addr_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               pending_reg, pending_next;
    logic [EVENT_W-1:0] event_reg, event_next;

    logic               done_reg, done_next;
    logic [DATA_W-1:0]  pos_count_reg, pos_count_next;
    logic [DATA_W-1:0]  neg_count_reg, neg_count_next;
    logic [DATA_W-1:0]  temp_count_reg, temp_count_next;
    logic               dump_due_reg, dump_due_next;
    logic               bad_index_reg, bad_index_next;

    logic [LW-1:0]      lines_in_use;
    logic [LW-1:0]      idx_ext;
    logic               idx_bad;
    logic               fold_last;
    logic [DATA_W-1:0]  add_a, add_b, add_sum;

    // Lines in use saturate at the bank depth.
    always_comb
    begin
        if (LW'(line_count) > LW'(MAX_LINES))
        begin
            lines_in_use = LW'(MAX_LINES);
        end
        else
        begin
            lines_in_use = LW'(line_count);
        end
    end

    assign idx_ext   = LW'(line_index);
    assign idx_bad   = (idx_ext >= lines_in_use);
    assign fold_last = ((LW'(fold_addr_reg) + LW'(1)) == lines_in_use);
    assign busy      = (state_reg != ST_IDLE);

    // The one adder: increments on hits, positive plus tentative on the fold walk.
    always_comb
    begin
        add_a = '0;
        add_b = DATA_W'(1);
        case (state_reg)
            ST_FOLD_WR:
            begin
                add_a = pos_rd;
                add_b = temp_rd;
            end
            ST_WR:
            begin
                case (op_reg)
                    OP_TENT: add_a = temp_rd;
                    OP_PASS: add_a = pos_rd;
                    OP_FAIL: add_a = neg_rd;
                    default: add_a = '0;
                endcase
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb
    begin
        raddr = (state_reg == ST_FOLD_RD) ? fold_addr_reg : idx_reg;
        case (state_reg)
            ST_CLEAR:   waddr = clr_addr_reg;
            ST_FOLD_WR: waddr = fold_addr_reg;
            default:    waddr = idx_reg;
        endcase
        wdata = (state_reg == ST_CLEAR) ? '0 : add_sum;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        fold_addr_next  = fold_addr_reg;
        clr_addr_next   = clr_addr_reg;
        pending_next    = pending_reg;
        event_next      = event_reg;
        bank_we         = '0;
        done_next       = 1'b0;
        pos_count_next  = pos_count_reg;
        neg_count_next  = neg_count_reg;
        temp_count_next = temp_count_reg;
        dump_due_next   = dump_due_reg;
        bad_index_next  = bad_index_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                bank_we = '{pos: 1'b1, neg: 1'b1, temp: 1'b1};
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode;
                    idx_next = idx_ext[AW-1:0];
                    if (idx_bad)
                    begin
                        done_next       = 1'b1;
                        pos_count_next  = '0;
                        neg_count_next  = '0;
                        temp_count_next = '0;
                        dump_due_next   = 1'b0;
                        bad_index_next  = 1'b1;
                    end
                    else if ((opcode == OP_PASS || opcode == OP_FAIL) && pending_reg)
                    begin
                        fold_addr_next = '0;
                        state_next     = ST_FOLD_RD;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FOLD_RD:
            begin
                state_next = ST_FOLD_WR;
            end
            ST_FOLD_WR:
            begin
                bank_we.pos = 1'b1;
                if (fold_last)
                begin
                    pending_next = 1'b0;
                    state_next   = ST_RD;
                end
                else
                begin
                    fold_addr_next = fold_addr_reg + AW'(1);
                    state_next     = ST_FOLD_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                done_next       = 1'b1;
                bad_index_next  = 1'b0;
                dump_due_next   = 1'b0;
                pos_count_next  = pos_rd;
                neg_count_next  = neg_rd;
                temp_count_next = temp_rd;
                if (op_reg != OP_READ)
                begin
                    event_next    = event_reg + EVENT_W'(1);
                    dump_due_next = (event_reg == '1);
                end
                case (op_reg)
                    OP_TENT:
                    begin
                        bank_we.temp    = 1'b1;
                        temp_count_next = add_sum;
                        pending_next    = 1'b1;
                    end
                    OP_PASS:
                    begin
                        bank_we.pos    = 1'b1;
                        pos_count_next = add_sum;
                    end
                    OP_FAIL:
                    begin
                        bank_we.neg    = 1'b1;
                        neg_count_next = add_sum;
                    end
                    default:
                    begin
                        bank_we = '0;
                    end
                endcase
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            fold_addr_reg <= '0;
            pending_reg   <= 1'b0;
            event_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fold_addr_reg <= fold_addr_next;
            pending_reg   <= pending_next;
            event_reg     <= event_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        pos_count_reg  <= pos_count_next;
        neg_count_reg  <= neg_count_next;
        temp_count_reg <= temp_count_next;
        dump_due_reg   <= dump_due_next;
        bad_index_reg  <= bad_index_next;
    end

    assign done       = done_reg;
    assign pos_count  = pos_count_reg;
    assign neg_count  = neg_count_reg;
    assign temp_count = temp_count_reg;
    assign dump_due   = dump_due_reg;
    assign bad_index  = bad_index_reg;

endmodule

// ===== tb/coverage_counter_bank_tb.sv =====
// Self-checking testbench for the coverage counter bank: counter mirror, command driver and checks.
module coverage_counter_bank_tb;

    import ccb_pkg::*;

    localparam int LINES_MAX    = 1024;
    localparam int RANDOM_ITEMS = 1150;

    // Byte addresses on the configuration port. The second one maps to no register.
    localparam logic [APB_ADDR_W-1:0] ADDR_LINE_COUNT = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] neg;
        logic [DATA_W-1:0] temp;
        logic              dump;
        logic              bad;
    } counter_reading_t;

    // Mirror of the three counter banks. It predicts the reading of every accepted
    // command and holds those readings in order until the block delivers them.
    class counter_mirror;
        bit [DATA_W-1:0]       pos_bank [LINES_MAX];
        bit [DATA_W-1:0]       neg_bank [LINES_MAX];
        bit [DATA_W-1:0]       temp_bank[LINES_MAX];
        bit                    fold_armed;
        bit [EVENT_W-1:0]      event_count;
        bit [LINE_COUNT_W-1:0] line_count;
        counter_reading_t      expected_q[$];
        int                    errors;
        int                    checked;
        int                    op_seen[4];
        int                    bad_seen;
        int                    folds;
        int                    dump_marks;

        function new();
            line_count = LINE_COUNT_RESET;
        endfunction

        function int unsigned lines_in_use();
            return (line_count > LINES_MAX) ? LINES_MAX : line_count;
        endfunction

        // Only word index zero holds a register; the upper data bits are dropped.
        function void store_config(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
            if ((addr >> 2) == CFG_IDX_LINE_COUNT)
                line_count = data[LINE_COUNT_W-1:0];
        endfunction

        function void note_command(logic [1:0] op, logic [INDEX_W-1:0] idx);
            counter_reading_t r;
            int unsigned      k;
            r = '0;
            op_seen[op]++;
            if (idx >= lines_in_use()) begin
                // Out-of-range line: nothing moves, not even the event counter.
                r.bad = 1'b1;
                bad_seen++;
            end
            else begin
                if (op != OP_READ) begin
                    if (op == OP_TENT) begin
                        temp_bank[idx]++;
                        fold_armed = 1'b1;
                    end
                    else begin
                        // The tentative bank is added in but left as it is.
                        if (fold_armed) begin
                            for (k = 0; k < lines_in_use(); k++)
                                pos_bank[k] += temp_bank[k];
                            fold_armed = 1'b0;
                            folds++;
                        end
                        if (op == OP_PASS)
                            pos_bank[idx]++;
                        else
                            neg_bank[idx]++;
                    end
                    event_count++;
                    if (event_count == 0) begin
                        r.dump = 1'b1;
                        dump_marks++;
                    end
                end
                r.pos  = pos_bank[idx];
                r.neg  = neg_bank[idx];
                r.temp = temp_bank[idx];
            end
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_result(counter_reading_t got);
            counter_reading_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.pos !== want.pos)
                report("pos_count", want.pos, got.pos);
            if (got.neg !== want.neg)
                report("neg_count", want.neg, got.neg);
            if (got.temp !== want.temp)
                report("temp_count", want.temp, got.temp);
            if (got.dump !== want.dump)
                report("dump_due", want.dump, got.dump);
            if (got.bad !== want.bad)
                report("bad_index", want.bad, got.bad);
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [1:0]            opcode     = OP_READ;
    logic [INDEX_W-1:0]    line_index = '0;
    logic                  done;
    logic [DATA_W-1:0]     pos_count;
    logic [DATA_W-1:0]     neg_count;
    logic [DATA_W-1:0]     temp_count;
    logic                  dump_due;
    logic                  bad_index;

    counter_mirror mirror = new();

    // Sender pacing: beats go out in bursts; when idling is on, each burst ends in a gap.
    int burst_left = 0;
    bit idle_on    = 1'b1;
    int random_sent;
    int settings_used;

    coverage_counter_bank dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .line_index (line_index),
        .done       (done),
        .pos_count  (pos_count),
        .neg_count  (neg_count),
        .temp_count (temp_count),
        .dump_due   (dump_due),
        .bad_index  (bad_index)
    );

    always #1 clk = ~clk;

    // The receiver has no way to stall, so every done cycle is a beat to check.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            mirror.check_result(counter_reading_t'({pos_count, neg_count, temp_count,
                                                    dump_due, bad_index}));
    end

    // Presents one command and holds it until the block takes it, i.e. until an edge
    // at which busy is seen low. The mirror is updated at that very edge. Lowering
    // start only when a gap follows keeps back-to-back beats free of a glitch.
    task automatic send(input logic [1:0] op, input logic [INDEX_W-1:0] idx);
        int gap;
        start      <= 1'b1;
        opcode     <= op;
        line_index <= idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        mirror.note_command(op, idx);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every expected reading is in, then lets the block settle
    // before the configuration may change.
    task automatic drain();
        start <= 1'b0;
        while (mirror.expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high.
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.store_config(addr, data);
    endtask

    // Changes the number of lines in use. Random junk rides in the unused upper bits.
    task automatic set_lines(input int unsigned lines);
        drain();
        apb_write(ADDR_LINE_COUNT, ($urandom << LINE_COUNT_W) | lines);
        settings_used++;
    endtask

    // Mostly a line in use; now and then any index, which may well be out of range.
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned lines;
        lines = mirror.lines_in_use();
        if (lines == 0 || $urandom_range(0, 99) < 12)
            return INDEX_W'($urandom);
        return INDEX_W'($urandom_range(0, lines - 1));
    endfunction

    // Well-formed sequences dominate: a run of tentative hits, the pass or fail that
    // folds them in, and a read of some line. The rest is loose random commands.
    task automatic random_phase(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) != 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send(OP_TENT, pick_index());
                    sent++;
                end
                send($urandom_range(0, 1) ? OP_PASS : OP_FAIL, pick_index());
                send(OP_READ, pick_index());
                sent += 2;
            end
            else begin
                send(2'($urandom_range(0, 3)), pick_index());
                sent++;
            end
        end
        random_sent += sent;
    endtask

    initial
    begin
        int unsigned lines;
        int          choice;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sweeps all three banks to zero with busy high; wait it out.
        do
            @(posedge clk);
        while (busy !== 1'b0);

        // Directed part at the reset line count, so the first folds walk all 1024
        // lines. Both ends of the index range and alternating bit patterns.
        send(OP_READ, 10'd0);
        send(OP_READ, 10'd1023);
        send(OP_TENT, 10'd0);
        send(OP_TENT, 10'd1023);
        send(OP_TENT, 10'h2AA);
        send(OP_READ, 10'h2AA);
        send(OP_PASS, 10'h155);
        send(OP_FAIL, 10'd1023);
        send(OP_PASS, 10'd0);
        send(OP_READ, 10'd1023);
        send(OP_TENT, 10'h155);
        send(OP_FAIL, 10'h2AA);
        send(OP_READ, 10'h155);

        // With no line in use every index is bad and a pending fold stays pending.
        set_lines(0);
        send(OP_TENT, 10'd0);
        send(OP_PASS, 10'd1023);
        send(OP_READ, 10'd0);

        // A line count above the bank depth acts as the full depth.
        set_lines(2047);
        send(OP_TENT, 10'd1023);
        send(OP_PASS, 10'd1023);

        // A write to an unmapped address must leave the line count alone.
        drain();
        apb_write(ADDR_UNMAPPED, 32'd3);
        send(OP_TENT, 10'd512);
        send(OP_READ, 10'd1023);

        // A single line in use: index one is already out of range.
        set_lines(1);
        send(OP_TENT, 10'd0);
        send(OP_TENT, 10'd1);
        send(OP_PASS, 10'd0);
        send(OP_READ, 10'd0);
        send(OP_FAIL, 10'd1);

        // Random phases. Small line counts keep folds short; the large settings, where a fold
        // reads and writes every line in use, get only a handful of commands.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 9);
            case (choice)
                0:       lines = 0;
                1:       lines = LINES_MAX;
                2:       lines = 2047;
                3:       lines = $urandom_range(17, 2047);
                default: lines = $urandom_range(1, 16);
            endcase
            set_lines(lines);
            idle_on = ($urandom_range(0, 3) != 0);
            random_phase((mirror.lines_in_use() > 64) ? 15 : 60);
        end

        drain();

        $display("Checked %0d result beats: %0d tentative, %0d pass, %0d fail, %0d read, %0d bad index.",
                 mirror.checked, mirror.op_seen[OP_TENT], mirror.op_seen[OP_PASS],
                 mirror.op_seen[OP_FAIL], mirror.op_seen[OP_READ], mirror.bad_seen);
        $display("Saw %0d folds and %0d dump marks over %0d line-count settings.",
                 mirror.folds, mirror.dump_marks, settings_used);
        if (mirror.errors == 0 && mirror.expected_q.size() == 0) begin
            $display("[coverage_counter_bank] OK");
        end
        else begin
            if (mirror.expected_q.size() != 0)
                $display("%0d expected result beats never arrived.", mirror.expected_q.size());
            $display("[coverage_counter_bank] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the reset sweep.
    initial
    begin
        #20000000;
        $display("Timeout with %0d result beats outstanding.", mirror.expected_q.size());
        $display("[coverage_counter_bank] ERROR");
        $finish;
    end

endmodule
